@@ src/sapd_pkg.sv @@
// shared types and constants for the spectrum average and peak decimation block
`timescale 1ns / 1ps
package sapd_pkg;

  localparam int FRAME_BINS  = 32768;
  localparam int LINE_PIXELS = 2048;
  localparam int POWER_BITS  = 24;
  localparam int SUM_BITS    = 34;
  localparam int POS_BITS    = $clog2(FRAME_BINS);
  localparam int PIX_BITS    = $clog2(LINE_PIXELS);
  localparam int CNT_BITS    = 11;
  localparam int QDEPTH      = 2;

  localparam logic [1:0] REG_AVG_COUNT      = 2'd0;
  localparam logic [1:0] REG_BINS_PER_PIXEL = 2'd1;
  localparam logic [1:0] REG_FIRST_BIN      = 2'd2;

  typedef struct packed {
    logic [POS_BITS-1:0]   pos;
    logic [POWER_BITS-1:0] power;
    logic                  strong_mark;
    logic                  first;
    logic                  last;
    logic [CNT_BITS-1:0]   n;
    logic [6:0]            nbpp;
    logic [14:0]           first_bin;
    logic                  blank;
  } entry_t;

endpackage

@@ src/sapd_front.sv @@
// front end: frame and group tracking, blank decision, configuration registers
`timescale 1ns / 1ps
module sapd_front import sapd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [POWER_BITS-1:0] bin_power,
  input  logic                  strong_flag,
  input  logic                  disk_data,
  input  logic [9:0]            half_symbol,
  input  logic [7:0]            period_second,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  output entry_t                entry
);

  logic [9:0]          avg_count;
  logic [6:0]          bins_per_pixel;
  logic [14:0]         first_bin;
  logic [9:0]          frames_summed;
  logic [POS_BITS-1:0] bin_position;
  logic [7:0]          previous_period_second;
  logic                line_blank;
  logic [CNT_BITS-1:0] n;
  logic                last;
  logic                blank_next;
  logic [6:0]          nbpp;

  always_comb begin
    n = {1'b0, frames_summed} + CNT_BITS'(1);
    last = n >= {1'b0, avg_count};
    blank_next = line_blank;
    if (bin_position == '0 && last) begin
      blank_next = (disk_data && half_symbol <= avg_count) ||
                   (!disk_data && period_second < previous_period_second);
    end
    if (bins_per_pixel == 7'd0) nbpp = 7'd1;
    else if (bins_per_pixel > 7'd64) nbpp = 7'd64;
    else nbpp = bins_per_pixel;
    entry.pos         = bin_position;
    entry.power       = bin_power;
    entry.strong_mark = strong_flag;
    entry.first       = frames_summed == 10'd0;
    entry.last        = last;
    entry.n           = n;
    entry.nbpp        = nbpp;
    entry.first_bin   = first_bin;
    entry.blank       = blank_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_count <= 10'd10;
      bins_per_pixel <= 7'd20;
      first_bin <= 15'd6144;
      frames_summed <= '0;
      bin_position <= '0;
      previous_period_second <= '0;
      line_blank <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_AVG_COUNT:      avg_count <= cfg_data[9:0];
          REG_BINS_PER_PIXEL: bins_per_pixel <= cfg_data[6:0];
          REG_FIRST_BIN:      first_bin <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        line_blank <= blank_next;
        if (bin_position == '0 && last) previous_period_second <= period_second;
        if (bin_position == POS_BITS'(FRAME_BINS - 1)) begin
          bin_position <= '0;
          frames_summed <= last ? 10'd0 : n[9:0];
        end else begin
          bin_position <= bin_position + POS_BITS'(1);
        end
      end
    end
  end

endmodule

@@ src/sapd_queue.sv @@
// short queue of classified bins between front and back
`timescale 1ns / 1ps
module sapd_queue import sapd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head
);

  entry_t     slots [QDEPTH];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign full = count == 2'(QDEPTH);
  assign not_empty = count != 2'd0;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

@@ src/sapd_back.sv @@
// back end: accumulator store, serial divider and peak reduction into pixels
`timescale 1ns / 1ps
module sapd_back import sapd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  entry_t                q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [POWER_BITS-1:0] pixel_value,
  output logic                  pixel_strong,
  output logic                  pixel_blank,
  output logic [PIX_BITS-1:0]   pixel_index,
  output logic                  last_pixel
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_PIX  = 3'd3;

  logic [SUM_BITS-1:0]   mem [FRAME_BINS];
  logic [SUM_BITS-1:0]   rd_data;
  logic [2:0]            state;
  entry_t                e;
  logic [SUM_BITS-1:0]   sum;
  logic                  wr_en;
  logic [PIX_BITS:0]     pix_cnt;
  logic [PIX_BITS:0]     pix_eff;
  logic [5:0]            bip;
  logic [POWER_BITS-1:0] rmax;
  logic [SUM_BITS-1:0]   quo;
  logic [CNT_BITS:0]     rem;
  logic [CNT_BITS:0]     rem_sh;
  logic [5:0]            step;
  logic [POWER_BITS-1:0] avg;
  logic [POWER_BITS-1:0] new_max;
  logic                  out_free;
  logic                  emit;

  assign q_pop = state == S_IDLE && q_valid;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    sum = e.first ? SUM_BITS'(e.power) : rd_data + SUM_BITS'(e.power);
    wr_en = state == S_SUM;
    pix_eff = (e.pos == '0) ? '0 : pix_cnt;
    rem_sh = {rem[CNT_BITS-1:0], quo[SUM_BITS-1]};
    avg = (quo[SUM_BITS-1:POWER_BITS] != '0) ? '1 : quo[POWER_BITS-1:0];
    new_max = (bip == 6'd0 || avg > rmax) ? avg : rmax;
    emit = ({1'b0, bip} + 7'd1) >= e.nbpp;
  end

  always_ff @(posedge clk) begin
    if (q_pop) rd_data <= mem[q_entry.pos];
    if (wr_en) mem[e.pos] <= sum;
  end

  always_ff @(posedge clk) begin
    if (q_pop) e <= q_entry;
    if (state == S_SUM) begin
      quo <= sum;
      rem <= '0;
      step <= '0;
    end else if (state == S_DIV) begin
      step <= step + 6'd1;
      if (rem_sh >= {1'b0, e.n}) begin
        rem <= rem_sh - {1'b0, e.n};
        quo <= {quo[SUM_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[SUM_BITS-2:0], 1'b0};
      end
    end
    if (state == S_PIX && emit && out_free) begin
      pixel_value <= e.blank ? '1 : new_max;
      pixel_strong <= e.blank ? 1'b0 : e.strong_mark;
      pixel_blank <= e.blank;
      pixel_index <= pix_cnt[PIX_BITS-1:0];
      last_pixel <= pix_cnt == (PIX_BITS+1)'(LINE_PIXELS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pix_cnt <= '0;
      bip <= '0;
      rmax <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && out_stall) || (state == S_PIX && emit && out_free);
      case (state)
        S_IDLE: begin
          if (q_valid) state <= S_SUM;
        end
        S_SUM: begin
          if (e.pos == '0) begin
            pix_cnt <= '0;
            bip <= '0;
            rmax <= '0;
          end
          if (e.last && e.pos > e.first_bin && pix_eff < (PIX_BITS+1)'(LINE_PIXELS))
            state <= S_DIV;
          else
            state <= S_IDLE;
        end
        S_DIV: begin
          if (step == 6'(SUM_BITS - 1)) state <= S_PIX;
        end
        S_PIX: begin
          if (!emit) begin
            rmax <= new_max;
            bip <= bip + 6'd1;
            state <= S_IDLE;
          end else if (out_free) begin
            rmax <= new_max;
            bip <= '0;
            pix_cnt <= pix_cnt + (PIX_BITS+1)'(1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/spectrum_average_peak_decimate_top.sv @@
// top level of the spectrum average and peak decimation block
`timescale 1ns / 1ps
// Usage: power bins enter one per transaction on the input channel (in_valid,
// in_stall), bin 0 of each frame first. Each bin is summed over avg_count
// frames; in the last frame of a group the average is reduced by maximum over
// bins_per_pixel bins after first_bin, and each pixel leaves on the output
// channel (out_valid, out_stall) once its last bin has been processed.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high.
// Flow: the back end handles one bin at a time. A bin that only accumulates
// passes through a store read, then add and write back; a bin of the last
// frame inside the pixel window then also passes the bit-serial divider and
// the peak compare. A two-entry queue lets the front take bins while the
// back end works.
// Reset clears all counters and the blank state; the accumulator store is not
// cleared, the first frame of a group overwrites it. When the receiver
// stalls, the pixel is held in the output register and the back end waits
// before emitting the next one; the input stalls once the queue is full.
module spectrum_average_peak_decimate_top import sapd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [POWER_BITS-1:0] bin_power,
  input  logic                  strong_flag,
  input  logic                  disk_data,
  input  logic [9:0]            half_symbol,
  input  logic [7:0]            period_second,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [POWER_BITS-1:0] pixel_value,
  output logic                  pixel_strong,
  output logic                  pixel_blank,
  output logic [PIX_BITS-1:0]   pixel_index,
  output logic                  last_pixel,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  entry_t front_entry;
  entry_t head;
  logic   full;
  logic   not_empty;
  logic   pop;

  assign in_stall = full;
  assign cfg_ready = 1'b1;

  sapd_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .bin_power(bin_power), .strong_flag(strong_flag), .disk_data(disk_data),
    .half_symbol(half_symbol), .period_second(period_second),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .entry(front_entry)
  );

  sapd_queue u_queue (
    .clk(clk), .rst(rst), .push(in_valid && !full), .push_entry(front_entry),
    .full(full), .pop(pop), .not_empty(not_empty), .head(head)
  );

  sapd_back u_back (
    .clk(clk), .rst(rst), .q_valid(not_empty), .q_entry(head), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .pixel_value(pixel_value),
    .pixel_strong(pixel_strong), .pixel_blank(pixel_blank),
    .pixel_index(pixel_index), .last_pixel(last_pixel)
  );

endmodule
